>>> hdl/peak_detector_delta_threshold_assert.svh
// Assertion helpers for the peak detector.
// They expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef PEAK_DETECTOR_DELTA_THRESHOLD_ASSERT_SVH
`define PEAK_DETECTOR_DELTA_THRESHOLD_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define PDDT_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: lbl");

// Antecedent in one cycle implies consequent in the next.
`define PDDT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

>>> hdl/pddt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pddt_pkg;

    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 16;
    localparam int WIDE_W   = SAMPLE_W + 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [INDEX_W-1:0]  index_t;
    typedef logic        [SAMPLE_W-1:0] delta_t;
    typedef logic signed [WIDE_W-1:0]   wide_t;

    // Register index, taken from paddr[2]
    typedef enum logic
    {
        REG_DELTA     = 1'b0,
        REG_THRESHOLD = 1'b1
    } cfg_reg_t;

endpackage

`default_nettype wire

>>> hdl/peak_detector_delta_threshold.sv
// Peak detector with delta hysteresis. One signed 16-bit sample word enters on the s_ side,
// with s_tuser high on the first sample of a record (it clears the tracking state, and that
// sample gets index 0). A sample above the running maximum becomes the new maximum and arms a
// pending peak; a sample more than delta below the maximum confirms the pending peak, sends
// its index on the m_ side and drops the maximum to the larger of the sample and threshold.
// All of the work is one compare/subtract stage feeding the state registers, so a sample is
// taken in every cycle while s_tready is high; a confirmed index goes into the output
// register behind m_tvalid, backed by a one-word skid register; s_tready falls only while the
// skid register holds a word, i.e. after the sink stalled across two peaks. Sample indices
// saturate at min(MAX_RECORD_LEN-1, 65535). delta (address 0x0) and threshold (address 0x4)
// are written over the APB port; the user must write them only while the stream is idle (not
// enforced by the block). A new threshold applies at the next maximum reset or record start.
`timescale 1ns / 1ps
`default_nettype none
`include "peak_detector_delta_threshold_assert.svh"

module peak_detector_delta_threshold #(
    parameter longint unsigned MAX_RECORD_LEN = 65536
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // sample stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire pddt_pkg::sample_t s_tdata,   // [15:0] sample
    input  wire logic              s_tuser,   // [0] record_start
    // peak stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output pddt_pkg::index_t       m_tdata,   // [15:0] peak_index
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    import pddt_pkg::*;

    // Highest index a sample can carry
    localparam index_t IDX_LIMIT = (MAX_RECORD_LEN - 64'd1 > 64'd65535) ?
                                   {INDEX_W{1'b1}} : INDEX_W'(MAX_RECORD_LEN - 64'd1);

    // Configuration registers
    delta_t  delta_reg;
    sample_t threshold_reg;

    // Tracking state
    sample_t running_max_reg, running_max_next;
    index_t  max_position_reg, max_position_next;
    logic    peak_pending_reg, peak_pending_next;
    index_t  sample_count_reg, sample_count_next;

    // Output register and skid register
    logic    out_valid_reg, out_valid_next;
    index_t  out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    index_t  skid_data_reg, skid_data_next;

    logic    cfg_wr;
    logic    in_acc;
    logic    out_pop;
    logic    push;

    sample_t max_start;
    index_t  pos_start;
    logic    pend_start;
    index_t  idx;
    logic    rise;
    logic    drop;
    wide_t   sample_w;
    wide_t   floor_w;
    sample_t reset_max;

    //--------------------------------------------------------------------------------------
    // APB: always ready, write on the access cycle
    //--------------------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg     <= '0;
            threshold_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_reg_t'(paddr[2]))
                REG_DELTA:     delta_reg     <= pwdata[SAMPLE_W-1:0];
                REG_THRESHOLD: threshold_reg <= pwdata[SAMPLE_W-1:0];
                default:       delta_reg     <= delta_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_reg_t'(paddr[2]))
            REG_DELTA:     prdata = {{(32-SAMPLE_W){1'b0}}, delta_reg};
            REG_THRESHOLD: prdata = {{(32-SAMPLE_W){threshold_reg[SAMPLE_W-1]}}, threshold_reg};
            default:       prdata = '0;
        endcase
    end

    //--------------------------------------------------------------------------------------
    // Handshakes: take a sample unless the skid word is occupied
    //--------------------------------------------------------------------------------------
    assign s_tready = !skid_valid_reg;
    assign in_acc   = s_tvalid && s_tready;
    assign out_pop  = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    //--------------------------------------------------------------------------------------
    // Per-sample step
    //--------------------------------------------------------------------------------------
    always_comb
    begin
        // Record start resets the tracking state ahead of this sample
        max_start  = s_tuser ? threshold_reg : running_max_reg;
        pos_start  = s_tuser ? '0 : max_position_reg;
        pend_start = s_tuser ? 1'b0 : peak_pending_reg;
        idx        = s_tuser ? '0 : sample_count_reg;

        // Widened difference so max - delta never wraps
        sample_w = {{2{s_tdata[SAMPLE_W-1]}}, s_tdata};
        floor_w  = {{2{max_start[SAMPLE_W-1]}}, max_start} - {2'b00, delta_reg};

        rise = s_tdata > max_start;
        // A rising sample is the new maximum and can never sit below it
        drop = !rise && (sample_w < floor_w);

        reset_max = (s_tdata > threshold_reg) ? s_tdata : threshold_reg;

        if (rise)
        begin
            running_max_next  = s_tdata;
            max_position_next = idx;
            peak_pending_next = 1'b1;
        end
        else if (drop)
        begin
            running_max_next  = reset_max;
            max_position_next = pos_start;
            peak_pending_next = 1'b0;
        end
        else
        begin
            running_max_next  = max_start;
            max_position_next = pos_start;
            peak_pending_next = pend_start;
        end

        // Hold the index at its limit
        sample_count_next = (idx < IDX_LIMIT) ? idx + 1'b1 : idx;

        push = in_acc && drop && pend_start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_max_reg  <= '0;
            max_position_reg <= '0;
            peak_pending_reg <= 1'b0;
            sample_count_reg <= '0;
        end
        else if (in_acc)
        begin
            running_max_reg  <= running_max_next;
            max_position_reg <= max_position_next;
            peak_pending_reg <= peak_pending_next;
            sample_count_reg <= sample_count_next;
        end
    end

    //--------------------------------------------------------------------------------------
    // Result buffering: output word first, skid word when the output is stalled
    //--------------------------------------------------------------------------------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (push)
        begin
            if (!out_valid_reg || out_pop)
            begin
                out_valid_next = 1'b1;
                out_data_next  = pos_start;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = pos_start;
            end
        end
        else if (out_pop)
        begin
            // Advance the skid word, or drop valid when nothing is behind
            out_valid_next  = skid_valid_reg;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    //--------------------------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------------------------
    `PDDT_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_reg || out_valid_reg)
    `PDDT_ASSERT_ALWAYS(a_count_limit, sample_count_reg <= IDX_LIMIT)
    `PDDT_ASSERT_ALWAYS(a_pos_not_ahead, max_position_reg <= sample_count_reg)
    `PDDT_ASSERT_NEXT(a_stall_fills_skid, push && out_valid_reg && !m_tready,
                      skid_valid_reg && !s_tready)
    `PDDT_ASSERT_NEXT(a_peak_clears_pending, push, !peak_pending_reg && m_tvalid)

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pddt_pkg::*;

    // Record length used for the block instance; the index tops out one below it
    localparam longint unsigned MAX_REC   = 65536;
    localparam int              INDEX_TOP = (MAX_REC - 1 > 65535) ? 65535 : int'(MAX_REC - 1);

    // One sample word as it travels on the input stream
    typedef struct packed
    {
        sample_t sample;
        logic    start;
    } sample_word_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    sample_t     s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    index_t      m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Words waiting to be sent, and peak indices waiting to come out
    sample_word_t sample_q[$];
    index_t       peak_q[$];
    int           in_flight  = 0;
    int           mismatches = 0;
    // Turn off idling on both sides while set
    logic         calm       = 1'b0;

    // Shadow copy of the block: registers and tracking state
    delta_t  cfg_delta  = '0;
    sample_t cfg_thresh = '0;
    int      trk_max    = 0;
    index_t  trk_pos    = '0;
    logic    trk_armed  = 1'b0;
    index_t  trk_count  = '0;

    peak_detector_delta_threshold #(
        .MAX_RECORD_LEN(MAX_REC)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Advance the shadow state by one accepted sample; queue the peak it confirms, if any.
    // All compares run on int, so the max-minus-delta difference cannot wrap.
    task automatic track_sample(input sample_t s, input logic start);
        int sv;
        sv = s;
        if (start)
        begin
            trk_max   = cfg_thresh;
            trk_pos   = '0;
            trk_armed = 1'b0;
            trk_count = '0;
        end
        if (sv > trk_max)
        begin
            trk_max   = sv;
            trk_pos   = trk_count;
            trk_armed = 1'b1;
        end
        if (sv < trk_max - int'(cfg_delta))
        begin
            if (trk_armed)
            begin
                peak_q.push_back(trk_pos);
                trk_armed = 1'b0;
            end
            trk_max = (sv > int'(cfg_thresh)) ? sv : int'(cfg_thresh);
        end
        // Hold the index at its top value on long records
        if (int'(trk_count) < INDEX_TOP)
            trk_count = trk_count + 1'b1;
    endtask

    // Driver: present the next queued word, idle at random, predict on every accepted word
    always @(posedge clk)
    begin : drive
        logic         fire;
        logic         gap;
        sample_word_t w;
        if (rst_n)
        begin
            fire = s_tvalid && s_tready;
            if (fire)
            begin
                track_sample(s_tdata, s_tuser);
                in_flight = in_flight - 1;
            end
            if (!s_tvalid || fire)
            begin
                gap = !calm && ($urandom_range(0, 99) < 28);
                if (sample_q.size() > 0 && !gap)
                begin
                    w = sample_q.pop_front();
                    s_tdata  <= w.sample;
                    s_tuser  <= w.start;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: stall the peak side at random, compare each accepted word with the oldest index
    always @(posedge clk)
    begin : watch
        index_t want;
        if (rst_n)
        begin
            m_tready <= calm || ($urandom_range(0, 99) >= 28);
            if (m_tvalid && m_tready)
            begin
                if (peak_q.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected peak word: peak_index=%0d", m_tdata);
                end
                else
                begin
                    want = peak_q.pop_front();
                    if (m_tdata !== want)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("peak_index mismatch: expected %0d, got %0d", want, m_tdata);
                    end
                end
            end
        end
    end

    task automatic push_word(input int s, input logic st);
        sample_q.push_back('{sample_t'(s), st});
        in_flight = in_flight + 1;
    endtask

    // Setup cycle, then access cycle; the register takes the value at the edge ending access
    task automatic write_reg(input cfg_reg_t r, input logic [15:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= (r == REG_THRESHOLD) ? {{16{v[15]}}, v} : {16'h0000, v};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (r == REG_DELTA)
            cfg_delta = v;
        else
            cfg_thresh = v;
    endtask

    // Hold until every word is accepted and every peak has come, then let the pipe empty
    task automatic wait_drain();
        while (in_flight != 0 || peak_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Random walk with steps on the scale of delta, so rises and confirming drops both occur.
    // About one word in twelve is full-range noise so every sample bit toggles.
    task automatic gen_wave(input int n, input int start_pct);
        int level;
        int span;
        int k;
        level = cfg_thresh;
        span  = int'(cfg_delta) * 2 + 8;
        if (span > 20000)
            span = 20000;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 99) < 8)
                push_word(int'(sample_t'($urandom)), $urandom_range(0, 99) < start_pct);
            else
            begin
                level = level + int'($urandom_range(0, 2 * span)) - span;
                if (level > 32767)
                    level = 32767;
                if (level < -32768)
                    level = -32768;
                push_word(level, $urandom_range(0, 99) < start_pct);
            end
        end
    endtask

    initial
    begin : main
        int ph;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings (delta 0, threshold 0); no record start yet, so the stream
        // counts as a record that began at reset
        push_word(0, 1'b0);
        push_word(5, 1'b0);
        push_word(5, 1'b0);          // equal to the maximum: no change
        push_word(4, 1'b0);          // confirms index 1
        push_word(32767, 1'b0);
        push_word(-32768, 1'b0);     // confirms index 4
        push_word(100, 1'b1);        // record start: index 0
        push_word(100, 1'b0);
        push_word(-1, 1'b0);         // confirms index 0, max drops to threshold
        wait_drain();

        // Change both registers inside the record: the maximum keeps its value
        write_reg(REG_DELTA, 16'd10);
        write_reg(REG_THRESHOLD, 16'h8000);
        push_word(20, 1'b0);
        push_word(10, 1'b0);         // exactly delta below: no change
        push_word(9, 1'b0);          // confirms
        push_word(-32768, 1'b1);
        push_word(32767, 1'b0);
        push_word(-32768, 1'b0);     // widest drop
        wait_drain();

        // Largest delta with either extreme threshold: the drop can never exceed it
        write_reg(REG_DELTA, 16'hFFFF);
        write_reg(REG_THRESHOLD, 16'h7FFF);
        push_word(32767, 1'b1);
        push_word(-32768, 1'b0);
        push_word(0, 1'b0);
        wait_drain();
        write_reg(REG_THRESHOLD, 16'h8000);
        push_word(32767, 1'b1);
        push_word(-32768, 1'b0);
        push_word(-32768, 1'b1);
        push_word(32767, 1'b0);
        wait_drain();

        // Random phases over a spread of settings; records run on across phases
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_DELTA, 16'd0);    write_reg(REG_THRESHOLD, 16'd0);   end
                1: begin write_reg(REG_DELTA, 16'd3);    write_reg(REG_THRESHOLD, 16'hFF9C); end
                2: begin write_reg(REG_DELTA, 16'd50);   write_reg(REG_THRESHOLD, 16'd0);   end
                3: begin write_reg(REG_DELTA, 16'd1000); write_reg(REG_THRESHOLD, 16'h8000); end
                4: begin write_reg(REG_DELTA, 16'hFFFF); write_reg(REG_THRESHOLD, 16'h7FFF); end
                5:
                begin
                    write_reg(REG_DELTA, 16'($urandom_range(0, 300)));
                    write_reg(REG_THRESHOLD, 16'($urandom));
                end
                6: begin write_reg(REG_DELTA, 16'd1);    write_reg(REG_THRESHOLD, 16'h7FFF); end
                default:
                begin
                    write_reg(REG_DELTA, 16'($urandom_range(0, 2000)));
                    write_reg(REG_THRESHOLD, 16'($urandom_range(0, 2000) - 1000));
                end
            endcase
            // Drop idling on both sides for one whole phase
            calm = (ph == 3);
            if (ph == 5)
            begin
                // Pause the sender mid-record until all peaks are out
                gen_wave(60, 4);
                wait_drain();
                gen_wave(60, 4);
            end
            else
                gen_wave(120, 4);
            wait_drain();
            calm = 1'b0;
        end

        // One longer record with a small delta and no record start inside it
        write_reg(REG_DELTA, 16'd20);
        write_reg(REG_THRESHOLD, 16'h8000);
        push_word(0, 1'b1);
        gen_wave(120, 0);
        wait_drain();

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Far beyond the slowest correct run
    initial
    begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
